>>> hdl/tsr_pkg.sv
// Shared types, codes and sizes for the TSN receive tracker.
// No dependencies; every other file of the block but tsr_ram imports this package.
package tsr_pkg;

  // Receive window in TSNs and depth of the duplicate queue.
  localparam int WINDOW    = 64;
  localparam int DUP_DEPTH = 16;

  // Depth of the queue between front and back.
  localparam int QDEPTH = 2;

  // Derived sizes.
  localparam int IDX_W   = $clog2(WINDOW);
  localparam int BLK_W   = $clog2(WINDOW / 2 + 1);
  localparam int FILL_W  = $clog2(DUP_DEPTH + 1);
  localparam int DUP_AW  = (DUP_DEPTH > 1) ? $clog2(DUP_DEPTH) : 1;
  localparam int QAW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Field widths fixed by the item format.
  localparam int TSN_W       = 32;
  localparam int OFFSET_W    = 16;
  localparam int GAP_COUNT_W = 6;
  localparam int DUP_COUNT_W = 5;

  localparam logic [31:0] ADV_WIN_RESET = 32'(65536 * 4);

  // Request type codes on the input channel.
  localparam logic [1:0] REQ_TYPE_INIT = 2'd0;
  localparam logic [1:0] REQ_TYPE_DATA = 2'd1;
  localparam logic [1:0] REQ_TYPE_SACK = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_GAP    = 2'd2;
  localparam logic [1:0] KIND_DUP    = 2'd3;

  // Data status codes.
  localparam logic [1:0] STAT_NEW    = 2'd0;
  localparam logic [1:0] STAT_DUP    = 2'd1;
  localparam logic [1:0] STAT_STALE  = 2'd2;
  localparam logic [1:0] STAT_BEYOND = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] seq_number;
  } req_item_t;

  typedef struct packed {
    logic [1:0]                   out_kind;
    logic [1:0]                   status;
    logic [31:0]                  seq_value;
    logic [OFFSET_W-1:0]          gap_start;
    logic [OFFSET_W-1:0]          gap_end;
    logic [GAP_COUNT_W-1:0]       gap_count;
    logic [DUP_COUNT_W-1:0]       dup_count;
    logic [31:0]                  adv_credit;
    logic                         dup_lost;
    logic                         last;
  } res_item_t;

  typedef enum logic [1:0] {
    KIND_INIT_REQ,
    KIND_DATA_REQ,
    KIND_SACK_REQ
  } req_kind_t;

  typedef struct packed {
    req_kind_t         kind;
    logic [TSN_W-1:0]  tsn;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_COUNT,
    ST_HEADER,
    ST_GAP,
    ST_DUP
  } back_state_t;

endpackage

>>> hdl/tsr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
module tsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/tsr_front.sv
// Front end of the TSN tracker: accepts request items, decodes their type and
// queues them for the back end. Depends on tsr_pkg.
module tsr_front
  import tsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output q_head_t   head,
  input  logic      pop
);

  q_entry_t          entries [QDEPTH];
  logic [QAW-1:0]    wr_ptr;
  logic [QAW-1:0]    rd_ptr;
  logic [QCNT_W-1:0] count;

  logic     accept;
  logic     keep;
  q_entry_t decoded;
  logic     do_pop;

  assign req_stall = (count == QCNT_W'(QDEPTH));
  assign accept    = req_valid && !req_stall;
  assign do_pop    = pop && (count != '0);

  always_comb begin
    decoded.tsn  = req.seq_number;
    decoded.kind = KIND_DATA_REQ;
    keep         = 1'b1;
    unique case (req.req_type)
      REQ_TYPE_INIT: decoded.kind = KIND_INIT_REQ;
      REQ_TYPE_DATA: decoded.kind = KIND_DATA_REQ;
      REQ_TYPE_SACK: decoded.kind = KIND_SACK_REQ;
      default:       keep = 1'b0;
    endcase
  end

  assign head.valid = (count != '0);
  assign head.entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      entries[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept && keep) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(accept && keep) - QCNT_W'(do_pop);
    end
  end

endmodule

>>> hdl/tsr_back.sv
// Back end of the TSN tracker: keeps the cumulative TSN, the receive bitmap
// and the duplicate queue, and produces all result items. Depends on tsr_pkg
// and tsr_ram.
module tsr_back
  import tsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  q_head_t     head,
  output logic        pop,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_data,
  output logic        res_valid,
  input  logic        res_stall,
  output res_item_t   res
);

  back_state_t state, state_next;

  logic [TSN_W-1:0]  cum, cum_next;
  logic [WINDOW-1:0] map, map_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic              ovf, ovf_next;
  logic [31:0]       adv_win;
  logic [IDX_W-1:0]  scan_idx, scan_idx_next;
  logic [BLK_W-1:0]  blk_cnt, blk_cnt_next;
  logic [BLK_W-1:0]  blk_done, blk_done_next;
  logic              in_block, in_block_next;
  logic [IDX_W-1:0]  blk_start, blk_start_next;
  logic [DUP_AW-1:0] dup_idx, dup_idx_next;
  logic              out_valid;
  res_item_t         out_item, out_item_next;
  logic              load;

  logic              can_load;
  logic              scan_end;
  logic              cur_bit, prev_bit, nxt_bit;
  logic              gap_ends, gap_step;
  logic [IDX_W-1:0]  start_eff;
  logic              has_dups;
  logic              head_init, head_data, head_sack;
  logic              dat_stale, dat_beyond, dat_seen;
  logic [TSN_W-1:0]  dat_off;
  logic              dup_we;
  logic [TSN_W-1:0]  dup_rdata;

  assign can_load  = !out_valid || !res_stall;
  assign scan_end  = (scan_idx == IDX_W'(WINDOW - 1));
  assign cur_bit   = map[scan_idx];
  assign prev_bit  = (scan_idx == '0) ? 1'b0 : map[scan_idx - 1'b1];
  assign nxt_bit   = scan_end ? 1'b0 : map[scan_idx + 1'b1];
  assign gap_ends  = cur_bit && !nxt_bit;
  assign gap_step  = !gap_ends || can_load;
  assign start_eff = in_block ? blk_start : scan_idx;
  assign has_dups  = (fill != '0);

  assign head_init = head.valid && (head.entry.kind == KIND_INIT_REQ);
  assign head_data = head.valid && (head.entry.kind == KIND_DATA_REQ);
  assign head_sack = head.valid && (head.entry.kind == KIND_SACK_REQ);

  // Data classification: stale, beyond the window, seen before, or new.
  assign dat_off    = head.entry.tsn - cum - 1'b1;
  assign dat_stale  = (head.entry.tsn <= cum);
  assign dat_beyond = (dat_off >= TSN_W'(WINDOW));
  assign dat_seen   = map[dat_off[IDX_W-1:0]];

  assign dup_we = (state == ST_IDLE) && head_data && can_load && !dat_stale &&
                  !dat_beyond && dat_seen && (fill < FILL_W'(DUP_DEPTH));

  tsr_ram #(
    .WIDTH (TSN_W),
    .DEPTH (DUP_DEPTH)
  ) u_dup_ram (
    .clk   (clk),
    .we    (dup_we),
    .waddr (fill[DUP_AW-1:0]),
    .wdata (head.entry.tsn),
    .raddr (dup_idx_next),
    .rdata (dup_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (head_sack) begin
          state_next = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        if (!map[0]) begin
          state_next = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (scan_end) begin
          state_next = ST_HEADER;
        end
      end
      ST_HEADER: begin
        if (can_load) begin
          if (blk_cnt != '0) begin
            state_next = ST_GAP;
          end else if (has_dups) begin
            state_next = ST_DUP;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_GAP: begin
        if (gap_step && scan_end) begin
          state_next = has_dups ? ST_DUP : ST_IDLE;
        end
      end
      ST_DUP: begin
        if (can_load && (FILL_W'(dup_idx) + 1'b1 == fill)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and result outputs.
  always_comb begin
    cum_next       = cum;
    map_next       = map;
    fill_next      = fill;
    ovf_next       = ovf;
    scan_idx_next  = scan_idx;
    blk_cnt_next   = blk_cnt;
    blk_done_next  = blk_done;
    in_block_next  = in_block;
    blk_start_next = blk_start;
    dup_idx_next   = dup_idx;
    pop            = 1'b0;
    load           = 1'b0;
    out_item_next  = '0;
    unique case (state)
      ST_IDLE: begin
        if (head_sack) begin
          pop = 1'b1;
        end else if (head_init && can_load) begin
          pop                     = 1'b1;
          load                    = 1'b1;
          cum_next                = head.entry.tsn - 1'b1;
          map_next                = WINDOW'(1);
          out_item_next.out_kind  = KIND_STATUS;
          out_item_next.status    = STAT_NEW;
          out_item_next.seq_value = head.entry.tsn - 1'b1;
          out_item_next.dup_lost  = ovf;
          out_item_next.last      = 1'b1;
        end else if (head_data && can_load) begin
          pop                    = 1'b1;
          load                   = 1'b1;
          out_item_next.out_kind = KIND_STATUS;
          if (dat_stale) begin
            out_item_next.status = STAT_STALE;
          end else if (dat_beyond) begin
            out_item_next.status = STAT_BEYOND;
          end else if (dat_seen) begin
            out_item_next.status = STAT_DUP;
            if (fill < FILL_W'(DUP_DEPTH)) begin
              fill_next = fill + 1'b1;
            end else begin
              ovf_next = 1'b1;
            end
          end else begin
            out_item_next.status = STAT_NEW;
            map_next[dat_off[IDX_W-1:0]] = 1'b1;
          end
          out_item_next.seq_value = cum;
          out_item_next.dup_lost  = ovf_next;
          out_item_next.last      = 1'b1;
        end
      end
      ST_ADVANCE: begin
        // Slide the window over the contiguous run of received TSNs.
        if (map[0]) begin
          cum_next = cum + 1'b1;
          map_next = map >> 1;
        end else begin
          scan_idx_next = '0;
          blk_cnt_next  = '0;
        end
      end
      ST_COUNT: begin
        if (cur_bit && !prev_bit) begin
          blk_cnt_next = blk_cnt + 1'b1;
        end
        scan_idx_next = scan_end ? '0 : scan_idx + 1'b1;
      end
      ST_HEADER: begin
        if (can_load) begin
          load                        = 1'b1;
          out_item_next.out_kind      = KIND_HEADER;
          out_item_next.seq_value     = cum;
          out_item_next.gap_count     = GAP_COUNT_W'(blk_cnt);
          out_item_next.dup_count     = DUP_COUNT_W'(fill);
          out_item_next.adv_credit    = adv_win;
          out_item_next.dup_lost      = ovf;
          out_item_next.last          = (blk_cnt == '0) && !has_dups;
          scan_idx_next               = '0;
          blk_done_next               = '0;
          in_block_next               = 1'b0;
          dup_idx_next                = '0;
          if ((blk_cnt == '0) && !has_dups) begin
            fill_next = '0;
            ovf_next  = 1'b0;
          end
        end
      end
      ST_GAP: begin
        if (gap_step) begin
          if (gap_ends) begin
            load                    = 1'b1;
            out_item_next.out_kind  = KIND_GAP;
            out_item_next.gap_start = OFFSET_W'(start_eff) + 1'b1;
            out_item_next.gap_end   = OFFSET_W'(scan_idx) + 1'b1;
            out_item_next.last      = (BLK_W'(blk_done + 1'b1) == blk_cnt) && !has_dups;
            blk_done_next           = blk_done + 1'b1;
          end
          in_block_next  = cur_bit && nxt_bit;
          blk_start_next = start_eff;
          scan_idx_next  = scan_end ? '0 : scan_idx + 1'b1;
          dup_idx_next   = '0;
          if (scan_end && !has_dups) begin
            fill_next = '0;
            ovf_next  = 1'b0;
          end
        end
      end
      ST_DUP: begin
        if (can_load) begin
          load                    = 1'b1;
          out_item_next.out_kind  = KIND_DUP;
          out_item_next.seq_value = dup_rdata;
          out_item_next.last      = (FILL_W'(dup_idx) + 1'b1 == fill);
          dup_idx_next            = dup_idx + 1'b1;
          if (FILL_W'(dup_idx) + 1'b1 == fill) begin
            fill_next = '0;
            ovf_next  = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res_valid = out_valid;
  assign res       = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cum       <= '0;
      map       <= '0;
      fill      <= '0;
      ovf       <= 1'b0;
      adv_win   <= ADV_WIN_RESET;
      scan_idx  <= '0;
      blk_cnt   <= '0;
      blk_done  <= '0;
      in_block  <= 1'b0;
      dup_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cum      <= cum_next;
      map      <= map_next;
      fill     <= fill_next;
      ovf      <= ovf_next;
      scan_idx <= scan_idx_next;
      blk_cnt  <= blk_cnt_next;
      blk_done <= blk_done_next;
      in_block <= in_block_next;
      dup_idx  <= dup_idx_next;
      if (cfg_valid) begin
        adv_win <= cfg_data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!res_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    blk_start <= blk_start_next;
    if (load) begin
      out_item <= out_item_next;
    end
  end

endmodule

>>> hdl/tsn_receive_tracker_sack.sv
// Top level of the receiver-side TSN tracker with selective acknowledgement.
// Depends on tsr_pkg, tsr_front, tsr_back and, through the back end, tsr_ram.
//
// Usage:
// The req channel (req_valid, req_stall, req) carries one request item per
// transfer: init with the initial TSN, data with a received TSN, or sack.
// The res channel (res_valid, res_stall, res) returns result items: one
// status item for each init or data item, and for a sack a header followed
// by the gap blocks and the queued duplicate TSNs. The flag last marks the
// final result item of each request. Request type 3 is dropped silently.
// The cfg channel (cfg_valid, cfg_ready, cfg_data) writes the advertised
// window; it is always ready and should be written only while the block is idle.
//
// Timing: the front queue holds two items. The back end takes one init or data
// item per cycle while res_stall is low. A sack runs through the bitmap one
// bit per cycle, pausing at the end of a gap block while res_stall holds the
// output: the back end slides the window over the contiguous TSNs, counts
// the gap blocks, emits the header, emits the gap blocks and then one item
// per queued duplicate.
// Reset clears the cumulative TSN, the bitmap and the duplicate count and
// sets the advertised window to 262144. While res_stall is high the current
// result item holds and the back end waits before loading another; the front
// keeps accepting items until its queue is full, then raises req_stall.
module tsn_receive_tracker_sack
  import tsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_item_t   req,
  output logic        res_valid,
  input  logic        res_stall,
  output res_item_t   res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  q_head_t head;
  logic    pop;

  // The window register is a plain flop, so writes are always taken.
  assign cfg_ready = 1'b1;

  tsr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .head      (head),
    .pop       (pop)
  );

  tsr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

>>> hdl/tsr_checker.sv
// Port-level checks for the TSN tracker, bound to the top level.
// Depends on tsr_pkg.
module tsr_checker
  import tsr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_stall,
  input res_item_t   res
);

  // High between a result item without last and the end of its request.
  logic mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid <= 1'b0;
    end else if (res_valid && !res_stall) begin
      mid <= !res.last;
    end
  end

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result item changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) && !rst |-> !res_valid)
    else $error("result item presented right after reset");

  a_mid_kind: assert property (@(posedge clk) disable iff (rst)
    mid && res_valid |-> (res.out_kind == KIND_GAP) || (res.out_kind == KIND_DUP))
    else $error("sack tail interrupted by a new response");

  a_start_kind: assert property (@(posedge clk) disable iff (rst)
    !mid && res_valid |-> (res.out_kind == KIND_STATUS) || (res.out_kind == KIND_HEADER))
    else $error("gap or duplicate item without a sack header");

endmodule

bind tsn_receive_tracker_sack tsr_checker u_tsr_checker (.*);
